@@ rtl/core/jse_pkg.sv @@
// Shared types, character codes and helpers for the JSON string escaper.
package jse_pkg;

	// Character codes
	localparam logic [7:0] QUOTE_CH   = 8'h22;
	localparam logic [7:0] BSLASH_CH  = 8'h5C;
	localparam logic [7:0] CH_U       = 8'h75;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_B       = 8'h62;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CH_N       = 8'h6E;
	localparam logic [7:0] CH_F       = 8'h66;
	localparam logic [7:0] CH_R       = 8'h72;
	localparam logic [7:0] CTRL_LIMIT = 8'd32;

	// Control codes with a two-character escape
	localparam logic [7:0] CTRL_BS = 8'd8;
	localparam logic [7:0] CTRL_HT = 8'd9;
	localparam logic [7:0] CTRL_LF = 8'd10;
	localparam logic [7:0] CTRL_FF = 8'd12;
	localparam logic [7:0] CTRL_CR = 8'd13;

	// Body lengths per kind
	localparam logic [2:0] LEN_NONE  = 3'd0;
	localparam logic [2:0] LEN_PLAIN = 3'd1;
	localparam logic [2:0] LEN_SHORT = 3'd2;
	localparam logic [2:0] LEN_UNI   = 3'd6;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_string;
		logic       last_of_string;
		logic       empty_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_out;
	} out_item_t;

	typedef enum logic [1:0] {
		BODY_NONE,
		BODY_PLAIN,
		BODY_SHORT,
		BODY_UNI
	} body_kind_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic       open_q;
		body_kind_t kind;
		logic [7:0] body;
		logic [2:0] body_len;
		logic [2:0] last_idx;
	} desc_t;

	// Lowercase hex digit for one nibble
	function automatic logic [7:0] hex_lower(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = CH_ZERO + {4'd0, nib};
		end else begin
			ch = 8'h61 + {4'd0, nib - 4'd10};
		end
		return ch;
	endfunction

endpackage

@@ rtl/core/jse_front.sv @@
// Front end: accepts input items and classifies each into an emission descriptor.
module jse_front import jse_pkg::*; (
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	input  logic     q_full,
	output logic     push,
	output desc_t    desc
);

	logic [7:0] c;
	logic [3:0] total;

	assign c          = item.data_byte;
	assign item_ready = !q_full;
	assign push       = item_valid && !q_full;

	// Classify the byte and work out how many bytes it expands to
	always_comb begin
		desc = '0;
		if (item.empty_string) begin
			desc.open_q   = 1'b1;
			desc.kind     = BODY_NONE;
			desc.body     = QUOTE_CH;
			desc.body_len = LEN_NONE;
		end else begin
			desc.open_q = item.first_of_string;
			if (c == QUOTE_CH || c == BSLASH_CH) begin
				desc.kind     = BODY_SHORT;
				desc.body     = c;
				desc.body_len = LEN_SHORT;
			end else if (c < CTRL_LIMIT) begin
				desc.kind     = BODY_SHORT;
				desc.body_len = LEN_SHORT;
				case (c)
					CTRL_BS: desc.body = CH_B;
					CTRL_HT: desc.body = CH_T;
					CTRL_LF: desc.body = CH_N;
					CTRL_FF: desc.body = CH_F;
					CTRL_CR: desc.body = CH_R;
					default: begin
						desc.kind     = BODY_UNI;
						desc.body     = c;
						desc.body_len = LEN_UNI;
					end
				endcase
			end else begin
				desc.kind     = BODY_PLAIN;
				desc.body     = c;
				desc.body_len = LEN_PLAIN;
			end
		end
		total = {3'd0, desc.open_q} + {1'b0, desc.body_len}
			+ {3'd0, item.empty_string | item.last_of_string};
		desc.last_idx = 3'(total - 4'd1);
	end

endmodule

@@ rtl/core/jse_queue.sv @@
// Short FIFO of descriptors between the front and back ends.
module jse_queue import jse_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t wdata,
	input  logic  pop,
	output desc_t head,
	output logic  head_valid,
	output logic  full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	desc_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == FULL_CNT);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Store incoming descriptors
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("queue occupancy beyond depth");

endmodule

@@ rtl/core/jse_back.sv @@
// Back end: steps through each descriptor and emits one output byte per cycle while res_ready allows.
module jse_back import jse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  desc_t     head,
	input  logic      head_valid,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res
);

	logic [2:0] idx_q;
	logic       res_valid_q;
	out_item_t  res_q;
	logic       load;
	logic       at_last;
	logic [2:0] bidx;
	logic [7:0] body_byte;
	logic [7:0] cur_byte;

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign load      = head_valid && (!res_valid_q || res_ready);
	assign at_last   = (idx_q == head.last_idx);
	assign pop       = load && at_last;
	assign bidx      = idx_q - {2'd0, head.open_q};

	// Pick the body byte at the current position
	always_comb begin
		body_byte = QUOTE_CH;
		unique case (head.kind)
			BODY_NONE:  body_byte = QUOTE_CH;
			BODY_PLAIN: body_byte = head.body;
			BODY_SHORT: body_byte = (bidx == 3'd0) ? BSLASH_CH : head.body;
			BODY_UNI: begin
				case (bidx)
					3'd0:    body_byte = BSLASH_CH;
					3'd1:    body_byte = CH_U;
					3'd4:    body_byte = hex_lower(head.body[7:4]);
					3'd5:    body_byte = hex_lower(head.body[3:0]);
					default: body_byte = CH_ZERO;
				endcase
			end
			default:    body_byte = QUOTE_CH;
		endcase
	end

	// Opening quote, then body, then closing quote
	always_comb begin
		if (head.open_q && idx_q == 3'd0) begin
			cur_byte = QUOTE_CH;
		end else if (bidx < head.body_len) begin
			cur_byte = body_byte;
		end else begin
			cur_byte = QUOTE_CH;
		end
	end

	// Load the output register and advance the position
	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_byte <= cur_byte;
			res_q.last_out <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				idx_q       <= at_last ? 3'd0 : idx_q + 3'd1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= head.last_idx)
		else $error("position ran past the end of the item");

	assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> idx_q == 3'd0)
		else $error("position not rewound while queue is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		load && !at_last |=> idx_q == $past(idx_q) + 3'd1 && res_valid_q && !res_q.last_out)
		else $error("mid-item step did not advance correctly");

endmodule

@@ rtl/core/json_string_escaper.sv @@
// Top level of the JSON string escaper: front classifier, descriptor queue, back sequencer.
//
//  Channel  Signals                          Payload     Accepted when
//  input    item_valid / item_ready / item   in_item_t   item_valid && item_ready
//  result   res_valid / res_ready / res      out_item_t  res_valid && res_ready
//
//  An item expands to 1..8 result bytes; the back sequencer emits one byte per cycle
//  while res_ready allows, a plain byte giving 1 result byte, a short escape 2 and a
//  \u00XX escape 6, plus one for each quote. Items enter at one per cycle until the
//  queue (QUEUE_DEPTH entries) is full. Reset empties the queue and clears res_valid;
//  no clearing pass. With res_ready low the output byte holds and the queue fills behind it.
module json_string_escaper import jse_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res
);

	desc_t desc;
	desc_t head;
	logic  push;
	logic  pop;
	logic  head_valid;
	logic  q_full;

	jse_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.desc       (desc)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wdata      (desc),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	jse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule
